// ----- rtl/vfs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the varint / fixed-width serializer.
// No dependencies; imported by vfs_ctrl, vfs_datapath and the top level.
package vfs_pkg;

    localparam int ValueWidth = 64;
    localparam int ByteWidth  = 8;
    localparam int GroupWidth = 7;
    localparam int CountWidth = 4;   // holds a byte count of up to 8

    localparam logic [ByteWidth-1:0]  CONT_BIT   = 8'h80;
    localparam logic [GroupWidth-1:0] GROUP_MASK = 7'h7f;

    // Input format codes
    typedef enum logic [2:0] {
        OP_FIX8     = 3'd0,
        OP_FIX16    = 3'd1,
        OP_FIX32    = 3'd2,
        OP_FIX64    = 3'd3,
        OP_VAR32    = 3'd4,
        OP_ZIGZAG32 = 3'd5,
        OP_VAR64    = 3'd6,
        OP_ZIGZAG64 = 3'd7
    } op_t;

    // Emission mode held for the item in flight
    typedef enum logic [1:0] {
        FMT_FIX_LE = 2'd0,
        FMT_FIX_BE = 2'd1,
        FMT_VAR    = 2'd2
    } fmt_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;   // capture a new item
        logic emit;   // move the next byte into the output register
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_last;  // the byte at the head of the shifter ends the item
    } dp_sts_t;

endpackage

// ----- rtl/vfs_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: format word loader, byte shifter and output byte register.
// Depends on vfs_pkg.
module vfs_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic [2:0]                  s_op,
    input  logic [63:0]                 s_value,
    input  vfs_pkg::dp_cmd_t            cmd,
    output vfs_pkg::dp_sts_t            sts,
    output logic [7:0]                  m_out_byte,
    output logic                        m_last
);
    import vfs_pkg::*;

    logic                  little_endian_reg;
    logic [ValueWidth-1:0] word_reg,  word_next;
    logic [CountWidth-1:0] count_reg, count_next;
    fmt_t                  fmt_reg,   fmt_next;
    logic [ByteWidth-1:0]  byte_reg,  byte_next;
    logic                  last_reg,  last_next;

    logic [ValueWidth-1:0] load_word;
    logic [CountWidth-1:0] load_count;
    fmt_t                  load_fmt;
    logic                  more;
    logic [31:0]           zz32;
    logic [ValueWidth-1:0] zz64;

    // Zigzag maps
    assign zz32 = {s_value[30:0], 1'b0} ^ {32{s_value[31]}};
    assign zz64 = {s_value[62:0], 1'b0} ^ {ValueWidth{s_value[63]}};

    // Big endian fields are left-aligned so the top byte always goes first.
    always_comb begin
        load_word  = '0;
        load_count = '0;
        load_fmt   = little_endian_reg ? FMT_FIX_LE : FMT_FIX_BE;
        case (op_t'(s_op))
            OP_FIX8: begin
                load_count = 4'd1;
                load_word  = little_endian_reg ? {56'd0, s_value[7:0]}
                                               : {s_value[7:0], 56'd0};
            end
            OP_FIX16: begin
                load_count = 4'd2;
                load_word  = little_endian_reg ? {48'd0, s_value[15:0]}
                                               : {s_value[15:0], 48'd0};
            end
            OP_FIX32: begin
                load_count = 4'd4;
                load_word  = little_endian_reg ? {32'd0, s_value[31:0]}
                                               : {s_value[31:0], 32'd0};
            end
            OP_FIX64: begin
                load_count = 4'd8;
                load_word  = s_value;
            end
            OP_VAR32: begin
                load_fmt  = FMT_VAR;
                load_word = {32'd0, s_value[31:0]};
            end
            OP_ZIGZAG32: begin
                load_fmt  = FMT_VAR;
                load_word = {32'd0, zz32};
            end
            OP_VAR64: begin
                load_fmt  = FMT_VAR;
                load_word = s_value;
            end
            OP_ZIGZAG64: begin
                load_fmt  = FMT_VAR;
                load_word = zz64;
            end
            default: begin
                load_fmt  = FMT_VAR;
                load_word = s_value;
            end
        endcase
    end

    // Varint continues while bits remain above the low group
    assign more = |word_reg[ValueWidth-1:GroupWidth];

    always_comb begin
        word_next  = word_reg;
        count_next = count_reg;
        fmt_next   = fmt_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        sts.is_last = 1'b0;
        case (fmt_reg)
            FMT_VAR:    sts.is_last = !more;
            FMT_FIX_LE,
            FMT_FIX_BE: sts.is_last = (count_reg == 4'd1);
            default:    sts.is_last = 1'b1;
        endcase
        if (cmd.load) begin
            word_next  = load_word;
            count_next = load_count;
            fmt_next   = load_fmt;
        end else if (cmd.emit) begin
            last_next  = sts.is_last;
            count_next = count_reg - 4'd1;
            case (fmt_reg)
                FMT_VAR: begin
                    byte_next = (more ? CONT_BIT : 8'h00)
                              | {1'b0, word_reg[GroupWidth-1:0] & GROUP_MASK};
                    word_next = word_reg >> GroupWidth;
                end
                FMT_FIX_LE: begin
                    byte_next = word_reg[ByteWidth-1:0];
                    word_next = word_reg >> ByteWidth;
                end
                FMT_FIX_BE: begin
                    byte_next = word_reg[ValueWidth-1 -: ByteWidth];
                    word_next = word_reg << ByteWidth;
                end
                default: begin
                    byte_next = word_reg[ByteWidth-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            little_endian_reg <= 1'b0;
            fmt_reg           <= FMT_VAR;
            count_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                little_endian_reg <= cfg_wr_data;
            end
            fmt_reg   <= fmt_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_out_byte = byte_reg;
    assign m_last     = last_reg;

endmodule

// ----- rtl/vfs_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: item sequencing and output valid handshake.
// Depends on vfs_pkg.
module vfs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output vfs_pkg::dp_cmd_t  cmd,
    input  vfs_pkg::dp_sts_t  sts
);
    import vfs_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cmd.load  = s_valid && (state_reg == ST_IDLE);
    assign cmd.emit  = (state_reg == ST_SEND) && slot_free;
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (cmd.emit) begin
                    m_valid_next = 1'b1;
                    if (sts.is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A byte moved into the output register is offered next cycle
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("emitted byte not presented");

    // A pending byte is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.emit)
        else $error("output byte overwritten while stalled");

    // Final byte of an item frees the input side
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.is_last) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after last byte");

    // No new item while one is being sent
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND) |-> !cmd.load)
        else $error("item loaded while busy");

endmodule

// ----- rtl/varint_fixed_serializer.sv -----
`timescale 1ns / 1ps
// Top level of the varint / fixed-width integer serializer.
// Depends on vfs_pkg, vfs_ctrl and vfs_datapath.
//
// Usage:
//   Input channel (s_valid/s_ready, s_op, s_value): one integer per item.
//     s_op picks fix8/16/32/64, var32, zigzag32, var64 or zigzag64.
//   Output channel (m_valid/m_ready, m_out_byte, m_last): one byte per transfer,
//     m_last flags the final byte of each input item.
//   Config: cfg_wr_en/cfg_wr_data write little_endian (fixed formats only,
//     0 = big endian). Write only while the block is idle.
// Sequence:
//   An item of n bytes (1..10) is loaded into the word register when it is
//   accepted and then shifted out a byte at a time, waiting while the output
//   register holds a byte that is not taken. The input side is not ready again
//   until the final byte has moved into the output register. m_valid rises
//   when the first byte enters the output register. The next item may be
//   accepted while the final byte of the previous one still sits in it.
// Reset: aresetn (synchronous, active low) clears the controller, drops
//   m_valid and sets little_endian to 0.
// Stall: when m_valid is high and m_ready low the output byte holds and the
//   shifter waits; nothing is dropped.
module varint_fixed_serializer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [63:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);
    import vfs_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencing and handshake
    vfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Word formatting, byte shifting, output register
    vfs_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_op        (s_op),
        .s_value     (s_value),
        .cmd         (cmd),
        .sts         (sts),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for varint_fixed_serializer: directed and random items,
// random idling on both channels, byte order changes between phases.
// Depends on vfs_pkg (op_t, CONT_BIT, GROUP_MASK) and the RTL top level.
module tb;
    import vfs_pkg::*;

    localparam int SETTLE_CYCLES = 4;    // idle margin before a register write
    localparam int DRAIN_CYCLES  = 30;   // watch for stray bytes at the end
    localparam int TIMEOUT_NS    = 2_000_000;

    // Work list for the driver: items plus control markers
    typedef enum logic [2:0] {
        REQ_ITEM,   // present one item on the input channel
        REQ_IDLE,   // hold valid low for a burst
        REQ_SYNC,   // wait until every expected byte has come
        REQ_CFG,    // write little_endian (block must be idle)
        REQ_CALM    // stop random stalls on the output side
    } req_kind_t;

    typedef struct {
        req_kind_t   kind;
        op_t         op;
        logic [63:0] value;
        int          arg;
    } drv_req_t;

    // One serialized byte as it should leave the block
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } ser_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    op_t         s_op        = OP_FIX8;
    logic [63:0] s_value     = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;

    drv_req_t  pending[$];    // driver work list, filled up front
    ser_byte_t byte_q[$];     // bytes predicted but not yet seen
    logic      le_mode    = 1'b0;   // predicted byte order register
    logic      sink_calm  = 1'b0;
    int        items_sent = 0;
    int        items_done = 0;
    int        wait_cnt   = 0;
    int        stall_left = 0;
    int        fails      = 0;

    varint_fixed_serializer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Expected byte stream for one accepted item, under the current byte order.
    task automatic encode_item(input op_t op, input logic [63:0] value);
        logic [63:0] word;
        logic [31:0] zz32;
        int          nbytes;
        int          idx;
        logic        is_var;
        is_var = 1'b1;
        nbytes = 0;
        zz32   = {value[30:0], 1'b0} ^ {32{value[31]}};
        case (op)
            OP_FIX8: begin
                word = {56'b0, value[7:0]};  nbytes = 1; is_var = 1'b0;
            end
            OP_FIX16: begin
                word = {48'b0, value[15:0]}; nbytes = 2; is_var = 1'b0;
            end
            OP_FIX32: begin
                word = {32'b0, value[31:0]}; nbytes = 4; is_var = 1'b0;
            end
            OP_FIX64: begin
                word = value;                nbytes = 8; is_var = 1'b0;
            end
            OP_VAR32:    word = {32'b0, value[31:0]};
            OP_ZIGZAG32: word = {32'b0, zz32};
            OP_VAR64:    word = value;
            default:     word = {value[62:0], 1'b0} ^ {64{value[63]}};  // full 64-bit zigzag
        endcase
        if (is_var) begin
            // low 7-bit groups first, continuation bit on all but the final byte
            while (word >= 64'(CONT_BIT)) begin
                byte_q.push_back(ser_byte_t'{{1'b0, word[6:0] & GROUP_MASK} | CONT_BIT, 1'b0});
                word = word >> 7;
            end
            byte_q.push_back(ser_byte_t'{word[7:0], 1'b1});
        end else begin
            for (int k = 0; k < nbytes; k++) begin
                idx = le_mode ? k : nbytes - 1 - k;
                byte_q.push_back(ser_byte_t'{word[8*idx +: 8], k == nbytes - 1});
            end
        end
    endtask

    // Driver: walks the work list; valid holds until the item is taken.
    always @(posedge aclk) begin : drv
        drv_req_t head;
        logic     valid_nxt;
        logic     we_nxt;
        logic     idle_now;
        valid_nxt = s_valid;
        we_nxt    = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                items_sent++;
                valid_nxt = 1'b0;
            end
            // idle: nothing on the input and every item fully emitted
            idle_now = !valid_nxt && (items_done == items_sent);
            if (!valid_nxt) begin
                if (wait_cnt != 0) begin
                    wait_cnt--;
                end else if (pending.size() != 0) begin
                    head = pending[0];
                    case (head.kind)
                        REQ_ITEM: begin
                            valid_nxt = 1'b1;
                            s_op    <= head.op;
                            s_value <= head.value;
                            pending.delete(0);
                        end
                        REQ_IDLE: begin
                            wait_cnt = head.arg;
                            pending.delete(0);
                        end
                        REQ_SYNC: if (idle_now) begin
                            wait_cnt = SETTLE_CYCLES;
                            pending.delete(0);
                        end
                        REQ_CFG: if (idle_now) begin
                            we_nxt = 1'b1;
                            cfg_wr_data <= head.arg[0];
                            pending.delete(0);
                        end
                        default: begin
                            sink_calm <= 1'b1;
                            pending.delete(0);
                        end
                    endcase
                end
            end
        end
        s_valid   <= valid_nxt;
        cfg_wr_en <= we_nxt;
    end

    // Monitor: checks outgoing bytes, predicts on accept, drives m_ready stalls.
    always @(posedge aclk) begin : mon
        ser_byte_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (cfg_wr_en)
                le_mode = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (byte_q.size() == 0) begin
                    $error("unexpected byte: out_byte %02h last %0d", m_out_byte, m_last);
                    fails++;
                end else begin
                    want = byte_q.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, m_out_byte);
                        fails++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_last);
                        fails++;
                    end
                end
                if (m_last)
                    items_done <= items_done + 1;
            end
            // checked before predicting: a new item's bytes never leave on its accept edge
            if (s_valid && s_ready)
                encode_item(s_op, s_value);
            // random stall bursts, none once calm
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= (stall_left == 0);
            end else if (!sink_calm && $urandom_range(0, 99) < 12) begin
                stall_left = $urandom_range(1, 9);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_item(input op_t op, input logic [63:0] value, input bit gaps);
        if (gaps && $urandom_range(0, 99) < 30)
            pending.push_back('{REQ_IDLE, OP_FIX8, 64'd0, $urandom_range(0, 8)});
        pending.push_back('{REQ_ITEM, op, value, 0});
    endtask

    task automatic queue_cfg(input bit le);
        pending.push_back('{REQ_SYNC, OP_FIX8, 64'd0, 0});
        pending.push_back('{REQ_CFG, OP_FIX8, 64'd0, int'(le)});
    endtask

    task automatic queue_random(input int count, input bit gaps);
        logic [63:0] v;
        for (int i = 0; i < count; i++) begin
            v = {$urandom, $urandom};
            // spread varint lengths: shift off a random number of top bits
            case ($urandom_range(0, 3))
                0: v = v >> $urandom_range(0, 63);
                1: v = v >> (8 * $urandom_range(0, 7));
                default: ;
            endcase
            queue_item(op_t'($urandom_range(0, 7)), v, gaps);
        end
    endtask

    initial begin
        // big endian, written explicitly right after reset
        queue_cfg(1'b0);

        // directed: field extremes, junk high bits, varint length edges
        queue_item(OP_FIX8,     64'd0, 1'b1);
        queue_item(OP_FIX8,     64'hffff_ffff_ffff_ff5a, 1'b1);
        queue_item(OP_FIX16,    64'hffff_ffff_ffff_1234, 1'b1);
        queue_item(OP_FIX32,    64'h1234_5678_dead_beef, 1'b1);
        queue_item(OP_FIX64,    64'h0123_4567_89ab_cdef, 1'b1);
        queue_item(OP_FIX64,    '1, 1'b1);
        queue_item(OP_VAR32,    64'd0, 1'b1);
        queue_item(OP_VAR32,    64'd127, 1'b1);
        queue_item(OP_VAR32,    64'd128, 1'b1);
        queue_item(OP_VAR32,    '1, 1'b1);
        queue_item(OP_ZIGZAG32, 64'd0, 1'b1);
        queue_item(OP_ZIGZAG32, 64'h0000_0000_ffff_ffff, 1'b1);   // -1
        queue_item(OP_ZIGZAG32, 64'hffff_ffff_8000_0000, 1'b1);   // most negative
        queue_item(OP_ZIGZAG32, 64'h0000_0000_7fff_ffff, 1'b1);
        queue_item(OP_VAR64,    64'd0, 1'b1);
        queue_item(OP_VAR64,    '1, 1'b1);                        // ten bytes
        queue_item(OP_VAR64,    64'h8000_0000_0000_0000, 1'b1);
        queue_item(OP_ZIGZAG64, 64'd0, 1'b1);
        queue_item(OP_ZIGZAG64, '1, 1'b1);
        queue_item(OP_ZIGZAG64, 64'h8000_0000_0000_0000, 1'b1);   // maps to all ones
        queue_item(OP_ZIGZAG64, 64'h7fff_ffff_ffff_ffff, 1'b1);
        queue_item(OP_ZIGZAG64, 64'h0000_0001_0000_0000, 1'b1);   // above 32 bits
        // fixed formats again in little endian
        queue_cfg(1'b1);
        queue_item(OP_FIX8,     64'hffff_ffff_ffff_ff5a, 1'b1);
        queue_item(OP_FIX16,    64'hffff_ffff_ffff_1234, 1'b1);
        queue_item(OP_FIX32,    64'h1234_5678_dead_beef, 1'b1);
        queue_item(OP_FIX64,    64'h0123_4567_89ab_cdef, 1'b1);

        // random phases, alternating byte order; last phase without idling
        queue_random(50, 1'b1);
        queue_cfg(1'b0);
        queue_random(50, 1'b1);
        queue_cfg(1'b1);
        pending.push_back('{REQ_CALM, OP_FIX8, 64'd0, 0});
        queue_random(44, 1'b0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_valid)
            @(negedge aclk);
        while (items_done != items_sent)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (byte_q.size() != 0) begin
            $error("%0d expected bytes never arrived", byte_q.size());
            fails++;
        end
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
